// ===== rtl/lhp_pkg.sv =====
// Shared constants, types and helper functions of the latency histogram.
`default_nettype none
package lhp_pkg;

    localparam int NUM_BUCKETS = 1024;
    localparam int IDX_W       = $clog2(NUM_BUCKETS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BUCKETS - 1);

    localparam int LAT_W  = 32;
    localparam int PCT_W  = 10;
    localparam int PCTL_W = 17;
    localparam int CNT_W  = 32;

    localparam int IN_DATA_W  = ((LAT_W + PCT_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((PCTL_W + 3 * LAT_W + 7) / 8) * 8;

    // Bucket width and its reciprocal: floor(x / 100) == (x * RECIP_100) >> 37 for 32-bit x.
    localparam int BIN_WIDTH_NS = 100;
    localparam logic [31:0] RECIP_100 = 32'h51EB851F;
    localparam int RECIP_SHIFT = 37;
    localparam int QUO_W = 64 - RECIP_SHIFT;

    // Percentile target arithmetic.
    localparam int PCT_SCALE = 1000;
    localparam int PROD_W    = CNT_W + PCT_W;
    localparam int SUM_W     = CNT_W + IDX_W;

    // floor(x / 1000) == (x * RECIP_1000) >> 52 for any x of PROD_W bits.
    localparam int RECIP_1000_W     = 43;
    localparam logic [RECIP_1000_W-1:0] RECIP_1000 = 43'h4189374BC6B;
    localparam int RECIP_1000_SHIFT = 52;
    localparam int SPLIT_W          = PROD_W / 2;
    localparam int MUL_W            = PROD_W + RECIP_1000_W;

    localparam logic REQ_RECORD = 1'b0;
    localparam logic REQ_QUERY  = 1'b1;

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        logic [CNT_W-1:0] wr_data;
    } mem_req_t;

    typedef struct packed {
        logic [CNT_W-1:0] total;
        logic [LAT_W-1:0] min_lat;
        logic [LAT_W-1:0] max_lat;
    } stats_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
    endfunction

endpackage
`default_nettype wire

// ===== rtl/lhp_bucket_mem.sv =====
// Bucket count memory with one write port and one registered read port.
`default_nettype none
module lhp_bucket_mem
(
    input  wire logic                  clk,
    input  wire lhp_pkg::mem_req_t     req,
    output logic [lhp_pkg::CNT_W-1:0]  rdata
);

    logic [lhp_pkg::CNT_W-1:0] mem [lhp_pkg::NUM_BUCKETS];
    logic [lhp_pkg::CNT_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rdata_reg <= mem[req.rd_addr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ===== rtl/lhp_record_pipe.sv =====
// Record path: bucket index, read-modify-write of the count, running statistics.
`default_nettype none
module lhp_record_pipe
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      rec_valid,
    input  wire logic [lhp_pkg::LAT_W-1:0] rec_lat,
    input  wire logic [lhp_pkg::CNT_W-1:0] rdata,
    output lhp_pkg::mem_req_t              req,
    output lhp_pkg::stats_t                stats,
    output logic                           busy
);

    logic [63:0]                   prod;
    logic                          s1_v_reg;
    logic [lhp_pkg::QUO_W-1:0]     s1_quo_reg;
    logic [lhp_pkg::IDX_W-1:0]     s1_idx;
    logic                          s2_v_reg;
    logic [lhp_pkg::IDX_W-1:0]     s2_idx_reg;
    logic                          wb_v_reg;
    logic [lhp_pkg::IDX_W-1:0]     wb_idx_reg;
    logic [lhp_pkg::CNT_W-1:0]     wb_data_reg;
    logic [lhp_pkg::CNT_W-1:0]     cur_count;
    logic [lhp_pkg::CNT_W-1:0]     new_count;
    lhp_pkg::stats_t               stats_reg;

    assign prod = 64'(rec_lat) * 64'(lhp_pkg::RECIP_100);

    assign s1_idx = (s1_quo_reg > lhp_pkg::QUO_W'(lhp_pkg::LAST_IDX)) ?
                    lhp_pkg::LAST_IDX : s1_quo_reg[lhp_pkg::IDX_W-1:0];

    // A write at the same edge as the read of the next record leaves stale read data.
    assign cur_count = (wb_v_reg && (wb_idx_reg == s2_idx_reg)) ? wb_data_reg : rdata;
    assign new_count = lhp_pkg::sat_inc(cur_count);

    always_comb
    begin
        req         = '0;
        req.rd_en   = s1_v_reg;
        req.rd_addr = s1_idx;
        req.wr_en   = s2_v_reg;
        req.wr_addr = s2_idx_reg;
        req.wr_data = new_count;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg          <= 1'b0;
            s2_v_reg          <= 1'b0;
            wb_v_reg          <= 1'b0;
            stats_reg.total   <= '0;
            stats_reg.min_lat <= '1;
            stats_reg.max_lat <= '0;
        end
        else
        begin
            s1_v_reg <= rec_valid;
            s2_v_reg <= s1_v_reg;
            wb_v_reg <= s2_v_reg;
            if (rec_valid)
            begin
                stats_reg.total <= lhp_pkg::sat_inc(stats_reg.total);
                if (rec_lat < stats_reg.min_lat)
                begin
                    stats_reg.min_lat <= rec_lat;
                end
                if (rec_lat > stats_reg.max_lat)
                begin
                    stats_reg.max_lat <= rec_lat;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s1_quo_reg  <= prod[63:lhp_pkg::RECIP_SHIFT];
        s2_idx_reg  <= s1_idx;
        wb_idx_reg  <= s2_idx_reg;
        wb_data_reg <= new_count;
    end

    assign stats = stats_reg;
    assign busy  = s1_v_reg | s2_v_reg;

`ifndef SYNTHESIS
    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        req.wr_en |-> (req.wr_data != '0))
        else $error("record path writes a zero bucket count");
`endif

endmodule
`default_nettype wire

// ===== rtl/lhp_target_div.sv =====
// Division of the percentile product by the percentile scale through a split reciprocal product.
`default_nettype none
module lhp_target_div
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [lhp_pkg::PROD_W-1:0] dividend,
    output logic                            done,
    output logic [lhp_pkg::PROD_W-1:0]      quotient
);

    logic [lhp_pkg::SPLIT_W-1:0]                      x_lo;
    logic [lhp_pkg::SPLIT_W-1:0]                      x_hi;
    logic [lhp_pkg::SPLIT_W-1:0]                      m_lo;
    logic [lhp_pkg::RECIP_1000_W-lhp_pkg::SPLIT_W-1:0] m_hi;
    logic [lhp_pkg::RECIP_1000_W-1:0]                 pp_ll_reg;
    logic [lhp_pkg::RECIP_1000_W-1:0]                 pp_lh_reg;
    logic [lhp_pkg::RECIP_1000_W-1:0]                 pp_hl_reg;
    logic [lhp_pkg::RECIP_1000_W-1:0]                 pp_hh_reg;
    logic [lhp_pkg::MUL_W-1:0]                        full_prod;
    logic                                             stage_v_reg;
    logic                                             done_reg;
    logic [lhp_pkg::PROD_W-1:0]                       quo_reg;

    assign x_lo = dividend[lhp_pkg::SPLIT_W-1:0];
    assign x_hi = dividend[lhp_pkg::PROD_W-1:lhp_pkg::SPLIT_W];
    assign m_lo = lhp_pkg::RECIP_1000[lhp_pkg::SPLIT_W-1:0];
    assign m_hi = lhp_pkg::RECIP_1000[lhp_pkg::RECIP_1000_W-1:lhp_pkg::SPLIT_W];

    // The four partial products are registered first and summed in the following cycle.
    assign full_prod = {pp_hh_reg, {(2 * lhp_pkg::SPLIT_W){1'b0}}}
                     + lhp_pkg::MUL_W'({pp_lh_reg, {lhp_pkg::SPLIT_W{1'b0}}})
                     + lhp_pkg::MUL_W'({pp_hl_reg, {lhp_pkg::SPLIT_W{1'b0}}})
                     + lhp_pkg::MUL_W'(pp_ll_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_v_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            stage_v_reg <= start;
            done_reg    <= stage_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            pp_ll_reg <= lhp_pkg::RECIP_1000_W'(x_lo) * lhp_pkg::RECIP_1000_W'(m_lo);
            pp_lh_reg <= lhp_pkg::RECIP_1000_W'(x_lo) * lhp_pkg::RECIP_1000_W'(m_hi);
            pp_hl_reg <= lhp_pkg::RECIP_1000_W'(x_hi) * lhp_pkg::RECIP_1000_W'(m_lo);
            pp_hh_reg <= lhp_pkg::RECIP_1000_W'(x_hi) * lhp_pkg::RECIP_1000_W'(m_hi);
        end
        if (stage_v_reg)
        begin
            quo_reg <= lhp_pkg::PROD_W'(full_prod[lhp_pkg::MUL_W-1:lhp_pkg::RECIP_1000_SHIFT]);
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

`ifndef SYNTHESIS
    a_done_timing: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##2 done)
        else $error("divider quotient not ready two cycles after start");
`endif

endmodule
`default_nettype wire

// ===== rtl/lhp_query_ctrl.sv =====
// Sequencer for the clearing pass, the percentile query walk and the result register.
`default_nettype none
module lhp_query_ctrl
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic                       in_type,
    input  wire logic [lhp_pkg::PCT_W-1:0]  in_pct,
    input  wire lhp_pkg::stats_t            stats,
    input  wire logic                       rec_busy,
    input  wire logic [lhp_pkg::CNT_W-1:0]  rdata,
    output lhp_pkg::mem_req_t               req,
    output logic                            div_start,
    output logic [lhp_pkg::PROD_W-1:0]      div_dividend,
    input  wire logic                       div_done,
    input  wire logic [lhp_pkg::PROD_W-1:0] div_quo,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [lhp_pkg::PCTL_W-1:0]      out_pct,
    output logic [lhp_pkg::LAT_W-1:0]       out_min,
    output logic [lhp_pkg::LAT_W-1:0]       out_max,
    output logic [lhp_pkg::CNT_W-1:0]       out_count
);

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_MUL   = 6'b000100,
        ST_DIV   = 6'b001000,
        ST_WALK  = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    state_t                         state_reg, state_next;
    logic [lhp_pkg::IDX_W-1:0]      clr_cnt_reg, clr_cnt_next;
    logic [lhp_pkg::PROD_W-1:0]     prod_reg, prod_next;
    logic [lhp_pkg::SUM_W-1:0]      target_reg, target_next;
    logic [lhp_pkg::SUM_W-1:0]      sum_reg, sum_next;
    logic [lhp_pkg::SUM_W-1:0]      sum_acc;
    logic [lhp_pkg::IDX_W-1:0]      walk_cnt_reg, walk_cnt_next;
    logic                           issue_done_reg, issue_done_next;
    logic                           rv_reg, rv_next;
    logic [lhp_pkg::IDX_W-1:0]      rv_idx_reg, rv_idx_next;
    logic                           hit_reg, hit_next;
    logic [lhp_pkg::IDX_W-1:0]      hit_idx_reg, hit_idx_next;
    logic [lhp_pkg::PCTL_W-1:0]     hit_edge;
    logic                           out_valid_reg, out_valid_next;
    logic [lhp_pkg::PCTL_W-1:0]     out_pct_reg, out_pct_next;
    lhp_pkg::stats_t                out_stats_reg, out_stats_next;

    assign sum_acc  = sum_reg + lhp_pkg::SUM_W'(rdata);
    assign hit_edge = lhp_pkg::PCTL_W'(lhp_pkg::PCTL_W'(hit_idx_reg) *
                                       lhp_pkg::PCTL_W'(lhp_pkg::BIN_WIDTH_NS));

    always_comb
    begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        prod_next       = prod_reg;
        target_next     = target_reg;
        sum_next        = sum_reg;
        walk_cnt_next   = walk_cnt_reg;
        issue_done_next = issue_done_reg;
        rv_next         = rv_reg;
        rv_idx_next     = rv_idx_reg;
        hit_next        = hit_reg;
        hit_idx_next    = hit_idx_reg;
        out_valid_next  = out_valid_reg;
        out_pct_next    = out_pct_reg;
        out_stats_next  = out_stats_reg;
        req             = '0;
        div_start       = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                req.wr_en    = 1'b1;
                req.wr_addr  = clr_cnt_reg;
                req.wr_data  = '0;
                clr_cnt_next = clr_cnt_reg + lhp_pkg::IDX_W'(1);
                if (clr_cnt_reg == lhp_pkg::LAST_IDX)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid && (in_type == lhp_pkg::REQ_QUERY))
                begin
                    prod_next  = lhp_pkg::PROD_W'(stats.total) * lhp_pkg::PROD_W'(in_pct);
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    target_next     = lhp_pkg::SUM_W'(div_quo);
                    sum_next        = '0;
                    walk_cnt_next   = '0;
                    issue_done_next = 1'b0;
                    rv_next         = 1'b0;
                    state_next      = ST_WALK;
                end
            end
            ST_WALK:
            begin
                rv_next = 1'b0;
                // The record path owns the memory port until its last write is out.
                if (!issue_done_reg && !rec_busy)
                begin
                    req.rd_en     = 1'b1;
                    req.rd_addr   = walk_cnt_reg;
                    rv_next       = 1'b1;
                    rv_idx_next   = walk_cnt_reg;
                    walk_cnt_next = walk_cnt_reg + lhp_pkg::IDX_W'(1);
                    if (walk_cnt_reg == lhp_pkg::LAST_IDX)
                    begin
                        issue_done_next = 1'b1;
                    end
                end
                if (rv_reg)
                begin
                    sum_next = sum_acc;
                    if (sum_acc >= target_reg)
                    begin
                        hit_next     = 1'b1;
                        hit_idx_next = rv_idx_reg;
                        state_next   = ST_DONE;
                    end
                    else if (rv_idx_reg == lhp_pkg::LAST_IDX)
                    begin
                        hit_next   = 1'b0;
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_pct_next   = hit_reg ? hit_edge : '0;
                    out_stats_next = stats;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg       <= prod_next;
        target_reg     <= target_next;
        sum_reg        <= sum_next;
        walk_cnt_reg   <= walk_cnt_next;
        issue_done_reg <= issue_done_next;
        rv_reg         <= rv_next;
        rv_idx_reg     <= rv_idx_next;
        hit_reg        <= hit_next;
        hit_idx_reg    <= hit_idx_next;
        out_pct_reg    <= out_pct_next;
        out_stats_reg  <= out_stats_next;
    end

    assign in_ready     = (state_reg == ST_IDLE);
    assign div_dividend = prod_reg;
    assign out_valid    = out_valid_reg;
    assign out_pct      = out_pct_reg;
    assign out_min      = out_stats_reg.min_lat;
    assign out_max      = out_stats_reg.max_lat;
    assign out_count    = out_stats_reg.total;

`ifndef SYNTHESIS
    a_walk_port_free: assert property (@(posedge clk) disable iff (!rst_n)
        req.rd_en |-> !rec_busy)
        else $error("bucket walk read issued while a record update is in flight");

    a_empty_answer: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_stats_reg.total == '0)) |-> (out_pct_reg == '0))
        else $error("empty histogram answered with a nonzero percentile");

    a_min_max_order: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_stats_reg.total != '0)) |->
        (out_stats_reg.min_lat <= out_stats_reg.max_lat))
        else $error("result carries a minimum above the maximum");
`endif

endmodule
`default_nettype wire

// ===== rtl/latency_histogram_percentile_unit.sv =====
// Top level of the latency histogram with percentile query.
//
// Input stream: tuser selects record (0) or query (1). A record carries a latency in ns and
// adds one to bucket latency/100 (the last bucket takes everything above), bumps the sample
// total and updates the running minimum and maximum. A record gives no output transfer.
// A query carries a percentile in tenths of a percent and returns one output transfer with
// the lower edge of the first bucket whose running sum reaches floor(total*p/1000), or 0 if
// none does, together with the minimum, the maximum and the sample total.
// Records are taken one per cycle while tready is high: a three-stage read-modify-write on
// the bucket memory, with forwarding between back-to-back updates of the same bucket.
// A query holds tready low until its result is loaded into the output register: a multiply,
// a reciprocal divide by 1000, then a walk of one bucket per cycle over the single memory read
// port, paused while the record path still has updates in flight; the walk stops at the first
// bucket that reaches the target, or at the last bucket when none does.
// The result sits in an output register, so records are taken again while it waits; a
// second query finishes its walk and then waits for that register to empty.
// After reset the block clears all NUM_BUCKETS (1024) entries of the bucket memory with
// tready low; all counters and statistics restart from their reset values.
`default_nettype none
module latency_histogram_percentile_unit
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // latency_ns [31:0], percentile_tenths [41:32], zero fill above
    input  wire logic [lhp_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // req_type [0]
    input  wire logic                           s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // percentile_ns [16:0], min_ns [48:17], max_ns [80:49], sample_count [112:81], zero fill
    output logic [lhp_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);

    localparam int FIELD_W = lhp_pkg::PCTL_W + 3 * lhp_pkg::LAT_W;

    logic                              rec_valid;
    logic                              rec_busy;
    lhp_pkg::mem_req_t                 rec_req;
    lhp_pkg::mem_req_t                 ctl_req;
    lhp_pkg::mem_req_t                 mem_req;
    lhp_pkg::stats_t                   stats;
    logic [lhp_pkg::CNT_W-1:0]         rdata;
    logic                              div_start;
    logic [lhp_pkg::PROD_W-1:0]        div_dividend;
    logic                              div_done;
    logic [lhp_pkg::PROD_W-1:0]        div_quo;
    logic [lhp_pkg::PCTL_W-1:0]        out_pct;
    logic [lhp_pkg::LAT_W-1:0]         out_min;
    logic [lhp_pkg::LAT_W-1:0]         out_max;
    logic [lhp_pkg::CNT_W-1:0]         out_count;

    assign rec_valid = s_axis_tvalid && s_axis_tready && (s_axis_tuser == lhp_pkg::REQ_RECORD);
    assign mem_req   = rec_busy ? rec_req : ctl_req;

    lhp_record_pipe u_record
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .rec_valid (rec_valid),
        .rec_lat   (s_axis_tdata[lhp_pkg::LAT_W-1:0]),
        .rdata     (rdata),
        .req       (rec_req),
        .stats     (stats),
        .busy      (rec_busy)
    );

    lhp_bucket_mem u_mem
    (
        .clk   (clk),
        .req   (mem_req),
        .rdata (rdata)
    );

    lhp_target_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .done     (div_done),
        .quotient (div_quo)
    );

    lhp_query_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .in_type      (s_axis_tuser),
        .in_pct       (s_axis_tdata[lhp_pkg::LAT_W +: lhp_pkg::PCT_W]),
        .stats        (stats),
        .rec_busy     (rec_busy),
        .rdata        (rdata),
        .req          (ctl_req),
        .div_start    (div_start),
        .div_dividend (div_dividend),
        .div_done     (div_done),
        .div_quo      (div_quo),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_pct      (out_pct),
        .out_min      (out_min),
        .out_max      (out_max),
        .out_count    (out_count)
    );

    assign m_axis_tdata = {{(lhp_pkg::OUT_DATA_W - FIELD_W){1'b0}},
                           out_count, out_max, out_min, out_pct};

endmodule
`default_nettype wire
